// File: rtl/assert_macros.svh
// Assertion helpers for the page tracker checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Checks that an antecedent implies a consequent in the following cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/pvrt_pkg.sv
package pvrt_pkg;
  localparam int BUFFER_SIZE_LOG2 = 29;
  localparam int WORD_COUNT = 2048;
  localparam int MAX_RUNS = 64;
  localparam int WIDX_W = $clog2(WORD_COUNT);
  localparam int RUN_W = $clog2(MAX_RUNS + 1);

  localparam logic [1:0] MODE_MARK = 2'd0;
  localparam logic [1:0] MODE_INVAL = 2'd1;
  localparam logic [1:0] MODE_REQ = 2'd2;
  localparam logic [1:0] MODE_KEEP = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RUN = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] start_address;
    logic [31:0] byte_length;
    logic        gpu_written;
    logic        exact_only;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] run_base;
    logic [31:0] range_length;
    logic        truncated;
    logic        last;
  } out_item_t;
endpackage

// File: rtl/page_validity_range_tracker.sv
// Page validity tracker. Each transfer walks the 64-page words its range covers one word
// at a time through a single shared word unit: a mark or invalidate steps each word
// through read, wait and write states after setup (invalidate first reads the edge words
// when widening), a run request reads each word and then scans it one run boundary at
// a time, and keep-only-GPU-written sweeps all 2048 words. After reset a clearing pass
// zeroes all 2048 words of both bitmaps before the first input transfer is taken.
// Results are built in a work register and moved to the output register only when it is
// free, so out_valid and out_data hold until taken; the block takes one input item at a
// time.
module page_validity_range_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pvrt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pvrt_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_data
);
  import pvrt_pkg::*;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_SETUP = 12'b000000000100,
    S_ERD   = 12'b000000001000,
    S_EWT   = 12'b000000010000,
    S_RD    = 12'b000000100000,
    S_WT    = 12'b000001000000,
    S_WR    = 12'b000010000000,
    S_SCAN  = 12'b000100000000,
    S_OUT   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_TAIL  = 12'b100000000000
  } state_t;

  logic [63:0] vmem [WORD_COUNT];
  logic [63:0] gmem [WORD_COUNT];
  logic [63:0] vrd_r, grd_r;

  state_t      state_r, state_nxt;
  logic [4:0]  psl_r;
  in_item_t    item_r;
  out_item_t   res_r, res_nxt;
  out_item_t   acc_r, acc_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [32:0] pf_r, pf_nxt, pl_r, pl_nxt, rs_r, rs_nxt;
  logic [26:0] w_r, w_nxt, wl_r, wl_nxt;
  logic        edge_r, edge_nxt;
  logic [63:0] inv_r, inv_nxt;
  logic [6:0]  p_r, p_nxt;
  logic        open_r, open_nxt;
  logic [RUN_W-1:0] n_r, n_nxt;
  logic        after_r, after_nxt;

  logic        we;
  logic [WIDX_W-1:0] waddr, raddr;
  logic [63:0] vwd, gwd;

  logic [4:0]  sh;
  logic [32:0] bs, st33, len33, lenc, endb;
  logic [63:0] smask, lowm, him, ge, srch;
  logic [6:0]  bl, tz, sb;
  logic        w_in;

  assign sh = (psl_r < 5'd12) ? 5'd12 : ((psl_r > 5'd16) ? 5'd16 : psl_r);
  assign bs = 33'd1 << BUFFER_SIZE_LOG2;
  assign st33 = {1'b0, item_r.start_address};
  assign len33 = {1'b0, item_r.byte_length};
  assign lenc = (len33 > bs - st33) ? bs - st33 : len33;
  assign endb = st33 + lenc - 33'd1;
  assign w_in = (w_r < 27'(WORD_COUNT));

  always_comb begin
    smask = '1;
    if (w_r == 27'(pf_r >> 6)) smask &= ~((64'd1 << pf_r[5:0]) - 64'd1);
    if (w_r == 27'(pl_r >> 6) && pl_r[5:0] != 6'd63)
      smask &= (64'd1 << (pl_r[5:0] + 6'd1)) - 64'd1;
  end

  assign lowm = (64'd1 << pf_r[5:0]) - 64'd1;
  assign him = ~((64'd1 << (7'(pl_r[5:0]) + 7'd1)) - 64'd1);
  assign ge = (p_r[6]) ? 64'd0 : ('1 << p_r[5:0]);
  assign srch = (open_r ? ~inv_r : inv_r) & ge;

  always_comb begin
    logic [63:0] g;
    bl = 7'd0;
    g = (w_in ? grd_r : 64'd0) & lowm;
    for (int i = 0; i < 64; i++) if (g[i]) bl = 7'(i + 1);
  end

  always_comb begin
    logic [63:0] g;
    tz = 7'd64;
    g = (w_in ? grd_r : 64'd0) & him;
    for (int i = 63; i >= 0; i--) if (g[i]) tz = 7'(i);
  end

  always_comb begin
    sb = 7'd64;
    for (int i = 63; i >= 0; i--) if (srch[i]) sb = 7'(i);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[waddr] <= vwd;
      gmem[waddr] <= gwd;
    end
    vrd_r <= vmem[raddr];
    grd_r <= gmem[raddr];
  end

  always_comb begin
    logic [32:0] bytes;
    state_nxt = state_r;
    res_nxt = res_r;
    acc_nxt = acc_r;
    ovalid_nxt = ovalid_r;
    pf_nxt = pf_r;
    pl_nxt = pl_r;
    rs_nxt = rs_r;
    w_nxt = w_r;
    wl_nxt = wl_r;
    edge_nxt = edge_r;
    inv_nxt = inv_r;
    p_nxt = p_r;
    open_nxt = open_r;
    n_nxt = n_r;
    after_nxt = after_r;
    we = 1'b0;
    waddr = w_r[WIDX_W-1:0];
    raddr = w_r[WIDX_W-1:0];
    vwd = 64'd0;
    gwd = 64'd0;
    bytes = 33'd0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        w_nxt = w_r + 27'd1;
        if (w_r == 27'(WORD_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        acc_nxt = '{status: ST_DONE, run_base: 32'd0, range_length: 32'd0,
                    truncated: 1'b0, last: 1'b1};
        if (item_r.mode == MODE_KEEP) begin
          w_nxt = 27'd0;
          wl_nxt = 27'(WORD_COUNT - 1);
          pf_nxt = 33'd0;
          pl_nxt = 33'(WORD_COUNT * 64 - 1);
          state_nxt = S_RD;
        end else if (item_r.mode == MODE_REQ) begin
          if (len33 == 0 || st33 > bs || bs - st33 < len33) begin
            acc_nxt.status = ST_EMPTY;
            state_nxt = S_OUT;
          end else begin
            pf_nxt = st33 >> sh;
            pl_nxt = (st33 + len33 - 33'd1) >> sh;
            w_nxt = 27'((st33 >> sh) >> 6);
            wl_nxt = 27'(((st33 + len33 - 33'd1) >> sh) >> 6);
            open_nxt = 1'b0;
            n_nxt = '0;
            after_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end else if (len33 == 0 || st33 >= bs) begin
          acc_nxt.status = ST_EMPTY;
          if (item_r.mode == MODE_INVAL) acc_nxt.range_length = '1;
          state_nxt = S_OUT;
        end else begin
          pf_nxt = st33 >> sh;
          pl_nxt = endb >> sh;
          w_nxt = 27'((st33 >> sh) >> 6);
          wl_nxt = 27'((endb >> sh) >> 6);
          edge_nxt = 1'b0;
          if (item_r.mode == MODE_INVAL && !item_r.exact_only) state_nxt = S_ERD;
          else state_nxt = S_RD;
        end
      end
      S_ERD: begin
        raddr = edge_r ? wl_r[WIDX_W-1:0] : w_r[WIDX_W-1:0];
        state_nxt = S_EWT;
      end
      S_EWT: begin
        if (!edge_r) begin
          if (pf_r[5:0] != 6'd0 && w_in) pf_nxt = {pf_r[32:6], 6'd0} + 33'(bl);
          else if (pf_r[5:0] != 6'd0) pf_nxt = {pf_r[32:6], 6'd0};
          edge_nxt = 1'b1;
          state_nxt = S_ERD;
        end else begin
          if (pl_r[5:0] != 6'd63) begin
            if (wl_r < 27'(WORD_COUNT))
              pl_nxt = {pl_r[32:6], 6'd0} + 33'((tz < 7'd1) ? 7'd0 : tz - 7'd1);
            else pl_nxt = {pl_r[32:6], 6'd63};
          end
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_WT;
      S_WT: begin
        if (item_r.mode == MODE_REQ) begin
          inv_nxt = ~(w_in ? vrd_r : 64'd0) & smask;
          p_nxt = 7'd0;
          state_nxt = S_SCAN;
        end else state_nxt = S_WR;
      end
      S_WR: begin
        we = w_in;
        case (item_r.mode)
          MODE_MARK: begin
            vwd = vrd_r | smask;
            gwd = item_r.gpu_written ? (grd_r | smask) : (grd_r & ~smask);
          end
          MODE_INVAL: begin
            vwd = vrd_r & ~smask;
            gwd = grd_r & ~smask;
          end
          default: begin
            vwd = grd_r;
            gwd = grd_r;
          end
        endcase
        w_nxt = w_r + 27'd1;
        if (w_r == wl_r) begin
          if (item_r.mode == MODE_INVAL) begin
            bytes = (pl_r - pf_r + 33'd1) << sh;
            acc_nxt.run_base = 32'(pf_r << sh);
            acc_nxt.range_length = bytes[32] ? 32'hFFFFFFFF : bytes[31:0];
          end
          state_nxt = S_OUT;
        end else state_nxt = S_RD;
      end
      S_SCAN: begin
        // One boundary per cycle unless a stalled output holds it: open or close a run at the next change.
        if (sb[6]) begin
          w_nxt = w_r + 27'd1;
          state_nxt = (w_r == wl_r) ? S_TAIL : S_RD;
        end else if (!open_r && n_r == RUN_W'(MAX_RUNS)) begin
          acc_nxt.truncated = 1'b1;
          state_nxt = S_FIN;
        end else if (!open_r) begin
          open_nxt = 1'b1;
          rs_nxt = {w_r, 6'd0} + 33'(sb);
          p_nxt = sb;
        end else if (!after_r || !ovalid_r || !out_stall) begin
          // Any run held in the work register goes out; the new one is held back.
          if (after_r) begin
            res_nxt = acc_r;
            ovalid_nxt = 1'b1;
          end
          acc_nxt = '{status: ST_RUN, run_base: rs_r[31:0],
                      range_length: 32'({w_r, 6'd0} + 33'(sb) - rs_r),
                      truncated: 1'b0, last: 1'b0};
          after_nxt = 1'b1;
          n_nxt = n_r + 1'b1;
          open_nxt = 1'b0;
          p_nxt = sb;
        end
      end
      S_TAIL: begin
        if (open_r && n_r == RUN_W'(MAX_RUNS)) begin
          acc_nxt.truncated = 1'b1;
          state_nxt = S_FIN;
        end else if (open_r) begin
          if (!after_r || !ovalid_r || !out_stall) begin
            if (after_r) begin
              res_nxt = acc_r;
              ovalid_nxt = 1'b1;
            end
            acc_nxt = '{status: ST_RUN, run_base: rs_r[31:0],
                        range_length: 32'(pl_r + 33'd1 - rs_r),
                        truncated: 1'b0, last: 1'b0};
            after_nxt = 1'b1;
            n_nxt = n_r + 1'b1;
            open_nxt = 1'b0;
          end
        end else if (!after_r) begin
          acc_nxt = '{status: ST_NONE, run_base: 32'd0, range_length: 32'd0,
                      truncated: 1'b0, last: 1'b1};
          state_nxt = S_OUT;
        end else state_nxt = S_FIN;
      end
      S_FIN: begin
        // The held-back run becomes the final one.
        if (!ovalid_r || !out_stall) begin
          res_nxt = acc_r;
          res_nxt.last = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          res_nxt = acc_r;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ovalid_r <= 1'b0;
      psl_r <= 5'd12;
      w_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      w_r <= w_nxt;
      if (cfg_valid) psl_r <= cfg_data;
    end
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    res_r <= res_nxt;
    acc_r <= acc_nxt;
    pf_r <= pf_nxt;
    pl_r <= pl_nxt;
    rs_r <= rs_nxt;
    wl_r <= wl_nxt;
    edge_r <= edge_nxt;
    inv_r <= inv_nxt;
    p_r <= p_nxt;
    open_r <= open_nxt;
    n_r <= n_nxt;
    after_r <= after_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data = res_r;
  assign cfg_ready = 1'b1;
endmodule

// File: rtl/pvrt_checker.sv
`include "assert_macros.svh"
module pvrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pvrt_pkg::out_item_t out_data,
  input logic                cfg_ready
);
  import pvrt_pkg::*;
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_ALWAYS(a_trunc_last, clk, rst_n, !(out_valid && out_data.truncated) || out_data.last)
  `CHK_ALWAYS(a_nonrun_last, clk, rst_n, !out_valid || out_data.status == ST_RUN || out_data.last)
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_ALWAYS(a_cfg_ready, clk, rst_n, cfg_ready)
endmodule

bind page_validity_range_tracker pvrt_checker u_pvrt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_ready(cfg_ready)
);

// File: sim/page_validity_range_tracker_tb.sv
`timescale 1ns / 1ps

module page_validity_range_tracker_tb;
  import pvrt_pkg::*;

  class page_state_scoreboard;
    bit [63:0]  valid_map [WORD_COUNT];
    bit [63:0]  gpu_map [WORD_COUNT];
    bit [4:0]   page_log2_reg;
    out_item_t  pending_results [$];
    int         mismatches;

    function void clear();
      foreach (valid_map[i]) begin
        valid_map[i] = '0;
        gpu_map[i] = '0;
      end
      page_log2_reg = 5'd12;
      mismatches = 0;
    endfunction

    function int page_shift();
      if (page_log2_reg < 12) return 12;
      if (page_log2_reg > 16) return 16;
      return page_log2_reg;
    endfunction

    function bit [63:0] read_word(bit gpu, longint unsigned w);
      if (w >= WORD_COUNT) return '0;
      return gpu ? gpu_map[w] : valid_map[w];
    endfunction

    function bit [63:0] page_mask(longint unsigned w, longint unsigned pf,
                                  longint unsigned pl);
      bit [63:0] m;
      m = '1;
      if (w == (pf >> 6)) m &= ~((64'd1 << (pf & 63)) - 1);
      if (w == (pl >> 6) && (pl & 63) != 63) m &= (64'd1 << ((pl & 63) + 1)) - 1;
      return m;
    endfunction

    function int low_zeros(bit [63:0] x);
      int n;
      n = 0;
      if (x == 0) return 64;
      while (x[0] == 1'b0) begin
        x >>= 1;
        n++;
      end
      return n;
    endfunction

    function int bit_length(bit [63:0] x);
      int n;
      n = 0;
      while (x != 0) begin
        x >>= 1;
        n++;
      end
      return n;
    endfunction

    function void push_result(logic [1:0] st, longint unsigned rs, longint unsigned rl,
                              bit tr, bit la);
      out_item_t r;
      r.status = st;
      r.run_base = rs[31:0];
      r.range_length = rl[31:0];
      r.truncated = tr;
      r.last = la;
      pending_results = {pending_results, r};
    endfunction

    function void note_transfer(in_item_t it);
      longint unsigned start, len, bs, pf, pl, w, wf, wl, bytes, rs;
      bit [63:0] m, g, inv;
      int sh, t, b, p, n;
      bit open, trunc;
      out_item_t runs [$];
      out_item_t r;

      start = it.start_address;
      len = it.byte_length;
      sh = page_shift();
      bs = 64'd1 << BUFFER_SIZE_LOG2;

      if (it.mode == MODE_KEEP) begin
        foreach (valid_map[i]) valid_map[i] = gpu_map[i];
        push_result(ST_DONE, 0, 0, 0, 1);
        return;
      end

      if (it.mode == MODE_MARK || it.mode == MODE_INVAL) begin
        if (len == 0 || start >= bs) begin
          push_result(ST_EMPTY, 0, (it.mode == MODE_INVAL) ? 64'hFFFF_FFFF : 0, 0, 1);
          return;
        end
        if (len > bs - start) len = bs - start;
        pf = start >> sh;
        pl = (start + len - 1) >> sh;
        if (it.mode == MODE_MARK) begin
          for (w = pf >> 6; w <= (pl >> 6); w++) begin
            m = page_mask(w, pf, pl);
            if (w < WORD_COUNT) begin
              valid_map[w] |= m;
              if (it.gpu_written) gpu_map[w] |= m;
              else gpu_map[w] &= ~m;
            end
          end
          push_result(ST_DONE, 0, 0, 0, 1);
        end else begin
          wf = pf >> 6;
          wl = pl >> 6;
          if (!it.exact_only) begin
            // Grow the range out within each edge word up to, but not over, the nearest GPU-written page.
            if ((pf & 63) != 0) begin
              g = read_word(1, wf) & ((64'd1 << (pf & 63)) - 1);
              pf = (pf & ~64'd63) + bit_length(g);
            end
            if ((pl & 63) != 63) begin
              g = read_word(1, wl) & ~((64'd1 << ((pl & 63) + 1)) - 1);
              t = low_zeros(g);
              if (t < 1) t = 1;
              pl = (pl & ~64'd63) + t - 1;
            end
          end
          for (w = wf; w <= wl; w++) begin
            m = page_mask(w, pf, pl);
            if (w < WORD_COUNT) begin
              valid_map[w] &= ~m;
              gpu_map[w] &= ~m;
            end
          end
          bytes = (pl - pf + 1) << sh;
          if (bytes > 64'hFFFF_FFFF) bytes = 64'hFFFF_FFFF;
          push_result(ST_DONE, pf << sh, bytes, 0, 1);
        end
        return;
      end

      // Run request: strict bounds, nothing clamped.
      if (len == 0 || start > bs || (bs - start) < len) begin
        push_result(ST_EMPTY, 0, 0, 0, 1);
        return;
      end
      rs = 0;
      open = 0;
      trunc = 0;
      n = 0;
      pf = start >> sh;
      pl = (start + len - 1) >> sh;
      for (w = pf >> 6; w <= (pl >> 6) && !trunc; w++) begin
        inv = ~read_word(0, w) & page_mask(w, pf, pl);
        p = 0;
        while (1) begin
          if (!open) begin
            m = inv & ({64{1'b1}} << p);
            if (m == 0) break;
            if (n == MAX_RUNS) begin
              trunc = 1;
              break;
            end
            b = low_zeros(m);
            open = 1;
            rs = w * 64 + b;
          end else begin
            m = ~inv & ({64{1'b1}} << p);
            if (m == 0) break;
            b = low_zeros(m);
            r = '{ST_RUN, rs[31:0], 32'(w * 64 + b - rs), 1'b0, 1'b0};
            runs = {runs, r};
            n++;
            open = 0;
          end
          p = b;
        end
      end
      if (!trunc && open) begin
        if (n == MAX_RUNS) trunc = 1;
        else begin
          r = '{ST_RUN, rs[31:0], 32'(pl + 1 - rs), 1'b0, 1'b0};
          runs = {runs, r};
          n++;
        end
      end
      if (n == 0) begin
        push_result(ST_NONE, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        r = runs[i];
        if (i == n - 1) begin
          r.last = 1;
          r.truncated = trunc;
        end
        pending_results = {pending_results, r};
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.status !== want.status) || (got.run_base !== want.run_base) ||
            (got.range_length !== want.range_length) ||
            (got.truncated !== want.truncated) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1;
  out_item_t  out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  page_state_scoreboard tracker_sb;
  bit idle_on = 1;
  int stall_left = 0;

  page_validity_range_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: a fresh stall length is drawn after every result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker_sb.check_result(out_data);
        stall_left = idle_on ? $urandom_range(0, 12) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker_sb.note_transfer(it);
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (tracker_sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_page_size(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker_sb.page_log2_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] md, logic [31:0] sa, logic [31:0] bl,
                                         bit gw, bit ex);
    in_item_t it;
    it.mode = md;
    it.start_address = sa;
    it.byte_length = bl;
    it.gpu_written = gw;
    it.exact_only = ex;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r, sh;
    sh = tracker_sb.page_shift();
    r = $urandom_range(0, 99);
    it.mode = (r < 36) ? MODE_MARK : (r < 68) ? MODE_INVAL : (r < 97) ? MODE_REQ : MODE_KEEP;
    it.gpu_written = 1'($urandom_range(0, 1));
    it.exact_only = 1'($urandom_range(0, 1));
    // Most ranges land in a small busy window so operations overlap each other.
    r = $urandom_range(0, 99);
    if (r < 75) it.start_address = $urandom_range(0, (300 << sh) - 1);
    else if (r < 85) it.start_address = $urandom_range(0, (1 << BUFFER_SIZE_LOG2) - 1);
    else if (r < 93)
      it.start_address = (1 << BUFFER_SIZE_LOG2) - $urandom_range(1, 200 << sh);
    else it.start_address = $urandom;
    r = $urandom_range(0, 99);
    if (r < 4) it.byte_length = 0;
    else if (r < 80) it.byte_length = $urandom_range(1, 12 << sh);
    else if (r < 96) it.byte_length = $urandom_range(1, 150 << sh);
    else it.byte_length = $urandom;
    return it;
  endfunction

  localparam logic [31:0] BUF_BYTES = 32'd1 << BUFFER_SIZE_LOG2;
  logic [4:0] page_settings [8] = '{5'd12, 5'd16, 5'd31, 5'd14, 5'd0, 5'd13, 5'd15, 5'd12};

  initial begin
    tracker_sb = new();
    tracker_sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners at the default page size.
    idle_on = 0;
    send_item(make_item(MODE_MARK, 32'd0, 32'd0, 1, 0));
    send_item(make_item(MODE_INVAL, BUF_BYTES, 32'd16, 0, 0));
    send_item(make_item(MODE_REQ, 32'd0, 32'd0, 0, 0));
    send_item(make_item(MODE_REQ, BUF_BYTES + 1, 32'd1, 0, 0));
    send_item(make_item(MODE_REQ, BUF_BYTES - 32'd4096, 32'd8192, 0, 0));
    send_item(make_item(MODE_REQ, 32'd0, BUF_BYTES, 0, 0));
    send_item(make_item(MODE_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
    send_item(make_item(MODE_MARK, 32'd0, 32'hFFFF_FFFF, 1, 0));
    send_item(make_item(MODE_REQ, BUF_BYTES - 32'd1, 32'd1, 0, 0));
    send_item(make_item(MODE_MARK, 32'h0001_0000, 32'h0004_0000, 0, 0));
    send_item(make_item(MODE_INVAL, 32'h0002_3000, 32'h0000_5000, 0, 0));
    send_item(make_item(MODE_INVAL, 32'h0001_8000, 32'h0000_1000, 0, 1));
    send_item(make_item(MODE_KEEP, 32'd0, 32'd0, 0, 0));
    send_item(make_item(MODE_REQ, 32'd0, 32'h0010_0000, 0, 0));
    // More than the maximum number of invalid runs: valid pages every other page.
    send_item(make_item(MODE_INVAL, 32'd0, 32'h0010_0000, 0, 1));
    for (int i = 0; i < 70; i++)
      send_item(make_item(MODE_MARK, i * 32'h2000, 32'd1, bit'(i % 2), 0));
    send_item(make_item(MODE_REQ, 32'd0, 32'h0010_0000, 0, 0));
    send_item(make_item(MODE_REQ, 32'h1000, 32'h0008_D000, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_page_size(page_settings[ph]);
      idle_on = (ph != 2);
      for (int i = 0; i < 40; i++) send_item(random_item());
      drain();
    end

    if (tracker_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
